@@ src/utf8d_pkg.sv @@
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

	localparam int CP_W  = 31;
	localparam int LEN_W = 3;
	localparam int ST_W  = 2;

	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_BAD_LEAD = 2'd1;
	localparam logic [ST_W-1:0] ST_BAD_CONT = 2'd2;

	// continuation byte pattern and payload mask
	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_MATCH = 8'h80;
	localparam logic [7:0] PAY6_MASK  = 8'h3F;

	typedef struct packed {
		logic [LEN_W-1:0] remaining;
		logic [LEN_W-1:0] total;
		logic [CP_W-1:0]  acc;
	} dec_state_t;

	typedef struct packed {
		logic [CP_W-1:0]  code_point;
		logic [LEN_W-1:0] sequence_length;
		logic [ST_W-1:0]  status;
	} dec_result_t;

endpackage

@@ src/utf8_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Byte-serial UTF-8 decoder with optional five- and six-byte forms.
// ----------------------------------------------------------------------------
// Takes one byte per clock and keeps that rate for as long as results are
// taken as fast as they appear. A byte is captured in an input register,
// decoded combinationally against the sequence state, and its result is
// written to the result register. A held result register stalls the
// input register, and then the input, until the result is taken. Valid lead
// bytes and middle continuation bytes produce no result. The long-form
// enable is sampled only at lead bytes.
module utf8_stream_decoder (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               data_valid,
	output logic                               data_ready,
	input  logic [7:0]                         data_byte,
	output logic                               result_valid,
	input  logic                               result_ready,
	output logic [utf8d_pkg::CP_W-1:0]         code_point,
	output logic [utf8d_pkg::LEN_W-1:0]        sequence_length,
	output logic [utf8d_pkg::ST_W-1:0]         status,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic                               cfg_data
);

	logic                    allow_q;
	logic                    v_s1;
	logic [7:0]              byte_s1;
	logic                    advance;
	utf8d_pkg::dec_state_t   state_q;
	utf8d_pkg::dec_state_t   state_nxt;
	logic                    emit;
	utf8d_pkg::dec_result_t  res;
	logic                    out_v_q;
	utf8d_pkg::dec_result_t  out_q;

	assign cfg_ready  = 1'b1;
	assign advance    = v_s1 && (!out_v_q || result_ready);
	assign data_ready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			allow_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (data_ready) begin
			v_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data_valid && data_ready) begin
			byte_s1 <= data_byte;
		end
	end

	utf8d_step u_step (
		.data_byte        (byte_s1),
		.allow_long_forms (allow_q),
		.cur              (state_q),
		.nxt              (state_nxt),
		.emit             (emit),
		.result           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (advance) begin
			out_v_q <= emit;
		end else if (result_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q <= res;
		end
	end

	assign result_valid    = out_v_q;
	assign code_point      = out_q.code_point;
	assign sequence_length = out_q.sequence_length;
	assign status          = out_q.status;

	// error beats carry no code point
	a_err_zero_cp: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != utf8d_pkg::ST_OK |-> code_point == '0)
		else $error("error beat with nonzero code point");

	// a sequence in progress always has a total length above its remaining count
	a_rem_lt_total: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.remaining != 3'd0 |-> state_q.total > state_q.remaining)
		else $error("remaining count not below sequence length");

	// single byte ok beats are ascii
	a_ascii: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == utf8d_pkg::ST_OK && sequence_length == 3'd1
		|-> code_point < 31'd128)
		else $error("single byte beat above ascii range");

	// a bad lead byte never leaves a sequence open
	a_bad_lead_idle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit && res.status == utf8d_pkg::ST_BAD_LEAD
		|=> state_q.remaining == 3'd0)
		else $error("bad lead left decoder busy");

	// a result that is held while not taken stays valid
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped while stalled");

endmodule

@@ src/utf8d_step.sv @@
// ----------------------------------------------------------------------------
// utf8d_step
// Next-state and result logic for one byte of the stream.
// ----------------------------------------------------------------------------
module utf8d_step (
	input  logic [7:0]              data_byte,
	input  logic                    allow_long_forms,
	input  utf8d_pkg::dec_state_t   cur,
	output utf8d_pkg::dec_state_t   nxt,
	output logic                    emit,
	output utf8d_pkg::dec_result_t  result
);

	logic                           is_cont;
	logic [utf8d_pkg::CP_W-1:0]     acc_shift;
	logic [utf8d_pkg::LEN_W-1:0]    rem_dec;
	logic [utf8d_pkg::LEN_W-1:0]    lead_len;
	logic [7:0]                     lead_bits;

	assign is_cont   = (data_byte & utf8d_pkg::CONT_MASK) == utf8d_pkg::CONT_MATCH;
	assign acc_shift = {cur.acc[utf8d_pkg::CP_W-7:0], data_byte[5:0] & utf8d_pkg::PAY6_MASK[5:0]};
	assign rem_dec   = cur.remaining - 3'd1;

	// lead byte classification, zero length means bad lead
	always_comb begin
		lead_len  = 3'd0;
		lead_bits = 8'h00;
		if ((data_byte & 8'hE0) == 8'hC0) begin
			lead_len  = 3'd2;
			lead_bits = data_byte & 8'h1F;
		end else if ((data_byte & 8'hF0) == 8'hE0) begin
			lead_len  = 3'd3;
			lead_bits = data_byte & 8'h0F;
		end else if ((data_byte & 8'hF8) == 8'hF0) begin
			lead_len  = 3'd4;
			lead_bits = data_byte & 8'h07;
		end else if (allow_long_forms && (data_byte & 8'hFC) == 8'hF8) begin
			lead_len  = 3'd5;
			lead_bits = data_byte & 8'h03;
		end else if (allow_long_forms && (data_byte & 8'hFE) == 8'hFC) begin
			lead_len  = 3'd6;
			lead_bits = data_byte & 8'h01;
		end
	end

	always_comb begin
		nxt    = cur;
		emit   = 1'b0;
		result = '0;
		if (cur.remaining != 3'd0) begin
			if (!is_cont) begin
				nxt                    = '0;
				emit                   = 1'b1;
				result.sequence_length = cur.total - cur.remaining + 3'd1;
				result.status          = utf8d_pkg::ST_BAD_CONT;
			end else if (rem_dec == 3'd0) begin
				nxt                    = '0;
				emit                   = 1'b1;
				result.code_point      = acc_shift;
				result.sequence_length = cur.total;
				result.status          = utf8d_pkg::ST_OK;
			end else begin
				nxt.remaining = rem_dec;
				nxt.acc       = acc_shift;
			end
		end else if (!data_byte[7]) begin
			emit                   = 1'b1;
			result.code_point      = {{(utf8d_pkg::CP_W-8){1'b0}}, data_byte};
			result.sequence_length = 3'd1;
			result.status          = utf8d_pkg::ST_OK;
		end else if (lead_len == 3'd0) begin
			emit                   = 1'b1;
			result.sequence_length = 3'd1;
			result.status          = utf8d_pkg::ST_BAD_LEAD;
		end else begin
			nxt.total     = lead_len;
			nxt.remaining = lead_len - 3'd1;
			nxt.acc       = {{(utf8d_pkg::CP_W-8){1'b0}}, lead_bits};
		end
	end

endmodule
